// File: hw/rtl/assert_macros.svh
// assertion macros used by the receiver top rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/slcfr_pkg.sv
// shared types, constants and crc function of the frame receiver
`default_nettype none

package slcfr_pkg;

    localparam int MAX_FRAME_DEFAULT = 64;

    localparam logic [7:0] CRC_POLY = 8'h07;

    // configuration register indexes
    localparam logic [1:0] REG_START_ONE  = 2'd0;
    localparam logic [1:0] REG_START_TWO  = 2'd1;
    localparam logic [1:0] REG_MAX_LENGTH = 2'd2;

    // result status codes
    localparam logic [1:0] RES_PAYLOAD = 2'd0;
    localparam logic [1:0] RES_EMPTY   = 2'd1;
    localparam logic [1:0] RES_CRC_ERR = 2'd2;

    localparam logic [7:0] START_ONE_RESET  = 8'd170;
    localparam logic [7:0] START_TWO_RESET  = 8'd85;
    localparam logic [6:0] MAX_LENGTH_RESET = 7'd64;

    typedef enum logic [2:0] {
        ST_SOF1,
        ST_SOF2,
        ST_LEN,
        ST_BODY,
        ST_FETCH,
        ST_LOAD
    } fsm_state_t;

    typedef struct packed {
        logic len_load;
        logic body_accept;
        logic fetch;
        logic run_load;
    } dp_cmd_t;

    typedef struct packed {
        logic match_one;
        logic match_two;
        logic len_ok;
        logic body_last;
        logic crc_ok;
        logic plen_zero;
        logic run_last;
        logic out_valid;
        logic out_free;
    } dp_status_t;

    // crc-8, msb first, one byte
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/slcfr_ctrl.sv
// controller state machine of the frame receiver
`default_nettype none

module slcfr_ctrl
    import slcfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire dp_status_t st,
    output dp_cmd_t         cmd
);

    fsm_state_t state_reg;
    fsm_state_t state_next;
    logic       in_xfer;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SOF1;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_SOF1, ST_SOF2:
            begin
                in_ready = 1'b1;
            end
            ST_LEN:
            begin
                in_ready     = 1'b1;
                cmd.len_load = in_valid && st.len_ok;
            end
            ST_BODY:
            begin
                // hold off the closing byte while a result still waits
                in_ready        = !(st.body_last && st.out_valid);
                cmd.body_accept = in_valid && in_ready;
            end
            ST_FETCH:
            begin
                cmd.fetch = 1'b1;
            end
            ST_LOAD:
            begin
                cmd.run_load = st.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign in_xfer = in_valid && in_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_SOF1:
            begin
                if (in_xfer && st.match_one)
                begin
                    state_next = ST_SOF2;
                end
            end
            ST_SOF2:
            begin
                if (in_xfer)
                begin
                    if (st.match_two)
                    begin
                        state_next = ST_LEN;
                    end
                    else if (!st.match_one)
                    begin
                        state_next = ST_SOF1;
                    end
                end
            end
            ST_LEN:
            begin
                if (in_xfer)
                begin
                    state_next = st.len_ok ? ST_BODY : ST_SOF1;
                end
            end
            ST_BODY:
            begin
                if (in_xfer && st.body_last)
                begin
                    state_next = (st.crc_ok && !st.plen_zero) ? ST_FETCH : ST_SOF1;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (st.out_free)
                begin
                    state_next = st.run_last ? ST_SOF1 : ST_FETCH;
                end
            end
            default:
            begin
                state_next = ST_SOF1;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/slcfr_dp.sv
// datapath of the frame receiver: config, body store, crc, counters, output register
`default_nettype none

module slcfr_dp
    import slcfr_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        out_ready,
    input  wire dp_cmd_t     cmd,
    output dp_status_t       st,
    output logic             out_valid,
    output logic [1:0]       status,
    output logic [7:0]       command,
    output logic [7:0]       payload_byte,
    output logic [5:0]       byte_index,
    output logic             last,
    output logic [31:0]      good_count,
    output logic [31:0]      bad_count
);

    localparam int LEN_W  = $clog2(MAX_FRAME + 1);
    localparam int ADDR_W = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
    localparam logic [8:0] MAX_LIM = 9'(MAX_FRAME);

    logic [7:0]       start_one_reg;
    logic [7:0]       start_two_reg;
    logic [6:0]       max_len_reg;

    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] pos_reg;
    logic [LEN_W-1:0] run_idx_reg;
    logic [7:0]       crc_reg;
    logic [7:0]       cmd_reg;
    logic [31:0]      good_reg;
    logic [31:0]      bad_reg;

    logic [7:0]       mem [MAX_FRAME];
    logic [7:0]       rd_data_reg;

    logic             out_valid_reg;
    logic [1:0]       out_status_reg;
    logic [7:0]       out_cmd_reg;
    logic [7:0]       out_pay_reg;
    logic [5:0]       out_idx_reg;
    logic             out_last_reg;

    logic [8:0]       limit;
    logic [LEN_W:0]   pos_inc;
    logic [LEN_W+1:0] run_end;
    logic [LEN_W-1:0] rd_addr;
    logic [LEN_W+5:0] idx_ext;
    logic [7:0]       frame_cmd;
    logic             frame_done;
    logic             single_load;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_one_reg <= START_ONE_RESET;
            start_two_reg <= START_TWO_RESET;
            max_len_reg   <= MAX_LENGTH_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_START_ONE:  start_one_reg <= cfg_data;
                REG_START_TWO:  start_two_reg <= cfg_data;
                REG_MAX_LENGTH: max_len_reg   <= cfg_data[6:0];
                default:        ;
            endcase
        end
    end

    assign limit   = ({2'b0, max_len_reg} > MAX_LIM) ? MAX_LIM : {2'b0, max_len_reg};
    assign pos_inc = {1'b0, pos_reg} + 1'b1;
    assign run_end = {2'b0, run_idx_reg} + (LEN_W + 2)'(3);
    assign rd_addr = run_idx_reg + 1'b1;
    assign idx_ext = {6'b0, run_idx_reg};

    // the command comes from cmd_reg, or from rx_byte when the closing transfer is the first body byte
    assign frame_cmd   = (pos_reg == '0) ? rx_byte : cmd_reg;
    assign frame_done  = cmd.body_accept && st.body_last;
    assign single_load = frame_done && (!st.crc_ok || st.plen_zero);

    always_comb
    begin
        st.match_one = (rx_byte == start_one_reg);
        st.match_two = (rx_byte == start_two_reg);
        st.len_ok    = (rx_byte >= 8'd2) && ({1'b0, rx_byte} <= limit);
        st.body_last = (pos_inc == {1'b0, len_reg});
        st.crc_ok    = (crc_reg == rx_byte);
        st.plen_zero = (len_reg == LEN_W'(2));
        st.run_last  = (run_end == {2'b0, len_reg});
        st.out_valid = out_valid_reg;
        st.out_free  = !out_valid_reg || out_ready;
    end

    // frame tracking and crc
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= '0;
            pos_reg     <= '0;
            run_idx_reg <= '0;
            crc_reg     <= '0;
            good_reg    <= '0;
            bad_reg     <= '0;
        end
        else
        begin
            if (cmd.len_load)
            begin
                len_reg     <= rx_byte[LEN_W-1:0];
                pos_reg     <= '0;
                run_idx_reg <= '0;
                crc_reg     <= '0;
            end
            if (cmd.body_accept)
            begin
                pos_reg <= pos_inc[LEN_W-1:0];
                if (!st.body_last)
                begin
                    crc_reg <= crc8_update(crc_reg, rx_byte);
                end
            end
            if (frame_done)
            begin
                if (st.crc_ok)
                begin
                    good_reg <= good_reg + 32'd1;
                end
                else
                begin
                    bad_reg <= bad_reg + 32'd1;
                end
            end
            if (cmd.run_load)
            begin
                run_idx_reg <= run_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.body_accept && (pos_reg == '0))
        begin
            cmd_reg <= rx_byte;
        end
    end

    // body store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.body_accept)
        begin
            mem[pos_reg[ADDR_W-1:0]] <= rx_byte;
        end
        if (cmd.fetch)
        begin
            rd_data_reg <= mem[rd_addr[ADDR_W-1:0]];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (single_load || cmd.run_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (single_load)
        begin
            out_status_reg <= st.crc_ok ? RES_EMPTY : RES_CRC_ERR;
            out_cmd_reg    <= frame_cmd;
            out_pay_reg    <= 8'd0;
            out_idx_reg    <= 6'd0;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.run_load)
        begin
            out_status_reg <= RES_PAYLOAD;
            out_cmd_reg    <= cmd_reg;
            out_pay_reg    <= rd_data_reg;
            out_idx_reg    <= idx_ext[5:0];
            out_last_reg   <= st.run_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign command      = out_cmd_reg;
    assign payload_byte = out_pay_reg;
    assign byte_index   = out_idx_reg;
    assign last         = out_last_reg;
    // counters only move at the closing transfer, which waits for an empty output
    assign good_count   = good_reg;
    assign bad_count    = bad_reg;

endmodule

`default_nettype wire

// File: hw/rtl/sync_length_crc8_frame_receiver.sv
// Serial frame receiver with crc-8 check.
// Input channel in_valid/in_ready/rx_byte takes one received byte per transfer;
// while hunting for the start bytes and collecting the body it takes one byte
// per cycle, bar a held-off closing byte. Config channel cfg_valid/cfg_ready/
// cfg_index/cfg_data is always ready: 0 first start byte, 1 second start byte,
// 2 max length. Output channel out_valid/out_ready carries status, command,
// payload_byte, byte_index, last, good_count and bad_count.
// A frame without payload or with a crc error gives one result, valid the cycle
// after the closing byte's transfer. A good frame with payload gives a run of
// payload results: each is read from the body store's registered read port in
// the fetch state, then loaded into the output register in the load state once
// the output is free; the next read waits for that load. No input is taken
// during the run. A finished result waits in the output register while the
// next frame's bytes are taken; only the closing byte of the next frame is held
// off until that result is gone. Reset restores the config defaults, clears
// both counters and restarts the hunt; the body store needs no clearing.
`default_nettype none
`include "assert_macros.svh"

module sync_length_crc8_frame_receiver
    import slcfr_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [7:0]       command,
    output logic [7:0]       payload_byte,
    output logic [5:0]       byte_index,
    output logic             last,
    output logic [31:0]      good_count,
    output logic [31:0]      bad_count
);

    dp_cmd_t    cmd;
    dp_status_t st;

    assign cfg_ready = 1'b1;

    slcfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    slcfr_dp #(
        .MAX_FRAME (MAX_FRAME)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .rx_byte      (rx_byte),
        .out_ready    (out_ready),
        .cmd          (cmd),
        .st           (st),
        .out_valid    (out_valid),
        .status       (status),
        .command      (command),
        .payload_byte (payload_byte),
        .byte_index   (byte_index),
        .last         (last),
        .good_count   (good_count),
        .bad_count    (bad_count)
    );

    // a closing byte never lands while a result still waits
    `ASSERT_SAME(a_close_needs_free_out, clk, rst_n,
        cmd.body_accept && st.body_last, !out_valid)

    // counters move only on a closing transfer
    `ASSERT_NEXT(a_counters_hold, clk, rst_n,
        !(cmd.body_accept && st.body_last),
        $stable(good_count) && $stable(bad_count))

    // a fetch always moves on to a state with no fetch and no input taken
    `ASSERT_NEXT(a_fetch_then_load_state, clk, rst_n, cmd.fetch, !cmd.fetch && !in_ready)

    // never an undefined status code on the output
    `ASSERT_SAME(a_status_code, clk, rst_n, out_valid,
        status == RES_PAYLOAD || status == RES_EMPTY || status == RES_CRC_ERR)

endmodule

`default_nettype wire

// File: verif/slcfr_frame_checker.sv
// frame receiver checker: predicts results from the channel transfers and compares them
`default_nettype none

module slcfr_frame_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [1:0]  status,
    input  wire logic [7:0]  command,
    input  wire logic [7:0]  payload_byte,
    input  wire logic [5:0]  byte_index,
    input  wire logic        last,
    input  wire logic [31:0] good_count,
    input  wire logic [31:0] bad_count,
    output int               mismatches,
    output int               pending,
    output int               results_seen,
    output int               good_frames_seen,
    output int               crc_errors_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import slcfr_pkg::*;

    localparam int BODY_DEPTH = MAX_FRAME_DEFAULT;

    typedef enum logic [1:0] {
        HUNT_ONE,
        HUNT_TWO,
        READ_LEN,
        READ_BODY
    } hunt_phase_e;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  command;
        logic [7:0]  payload_byte;
        logic [5:0]  byte_index;
        logic        last;
        logic [31:0] good_count;
        logic [31:0] bad_count;
    } frame_result_t;

    logic [7:0]    start_one;
    logic [7:0]    start_two;
    logic [6:0]    len_max;
    hunt_phase_e   hunt_phase;
    logic [6:0]    frame_len;
    logic [6:0]    body_pos;
    logic [7:0]    body_mem [BODY_DEPTH];
    logic [31:0]   good_total;
    logic [31:0]   bad_total;
    frame_result_t frame_results_due[$];
    int            fault_count;
    int            result_count;

    // crc-8 over the first count body bytes of the current frame
    function automatic logic [7:0] body_crc(input int count);
        logic [7:0] c;
        int         i;
        c = 8'h00;
        for (i = 0; i < count; i++)
        begin
            c = c ^ body_mem[i];
            repeat (8)
                c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    task automatic queue_result(input logic [1:0] code, input logic [7:0] cmd,
                                input logic [7:0] data, input logic [5:0] idx,
                                input logic is_last);
        frame_result_t r;
        r.status       = code;
        r.command      = cmd;
        r.payload_byte = data;
        r.byte_index   = idx;
        r.last         = is_last;
        r.good_count   = good_total;
        r.bad_count    = bad_total;
        frame_results_due.push_back(r);
    endtask

    task automatic predict_byte(input logic [7:0] b);
        int plen;
        int limit;
        int i;
        case (hunt_phase)
            HUNT_ONE:
            begin
                if (b == start_one)
                    hunt_phase = HUNT_TWO;
            end
            HUNT_TWO:
            begin
                // a repeated first start byte keeps the hunt where it is
                if (b == start_two)
                    hunt_phase = READ_LEN;
                else if (b != start_one)
                    hunt_phase = HUNT_ONE;
            end
            READ_LEN:
            begin
                limit = (len_max > BODY_DEPTH) ? BODY_DEPTH : len_max;
                if (b < 2 || b > limit)
                begin
                    hunt_phase = HUNT_ONE;
                end
                else
                begin
                    frame_len  = b[6:0];
                    body_pos   = 7'd0;
                    hunt_phase = READ_BODY;
                end
            end
            default:
            begin
                if (body_pos < BODY_DEPTH)
                    body_mem[body_pos] = b;
                body_pos = body_pos + 7'd1;
                if (body_pos >= frame_len)
                begin
                    plen = frame_len - 2;
                    if (body_crc(frame_len - 1) == body_mem[frame_len - 1])
                    begin
                        good_total = good_total + 32'd1;
                        if (plen == 0)
                        begin
                            queue_result(RES_EMPTY, body_mem[0], 8'h00, 6'd0, 1'b1);
                        end
                        else
                        begin
                            for (i = 0; i < plen; i++)
                                queue_result(RES_PAYLOAD, body_mem[0], body_mem[1 + i],
                                             6'(i), i + 1 == plen);
                        end
                    end
                    else
                    begin
                        bad_total = bad_total + 32'd1;
                        queue_result(RES_CRC_ERR, body_mem[0], 8'h00, 6'd0, 1'b1);
                    end
                    hunt_phase = HUNT_ONE;
                end
            end
        endcase
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            fault_count++;
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        frame_result_t want;
        if (!rst_n)
        begin
            start_one    = START_ONE_RESET;
            start_two    = START_TWO_RESET;
            len_max      = MAX_LENGTH_RESET;
            hunt_phase   = HUNT_ONE;
            frame_len    = 7'd0;
            body_pos     = 7'd0;
            good_total   = 32'd0;
            bad_total    = 32'd0;
            fault_count  = 0;
            result_count = 0;
            frame_results_due.delete();
            mismatches       <= 0;
            pending          <= 0;
            results_seen     <= 0;
            good_frames_seen <= 0;
            crc_errors_seen  <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_START_ONE:  start_one = cfg_data;
                    REG_START_TWO:  start_two = cfg_data;
                    REG_MAX_LENGTH: len_max   = cfg_data[6:0];
                    default:        ; // unused index, ignored
                endcase
            end

            if (out_valid && out_ready)
            begin
                result_count++;
                if (frame_results_due.size() == 0)
                begin
                    fault_count++;
                    $display("%0t: expected no result, got status 0x%0h command 0x%0h",
                             $time, status, command);
                end
                else
                begin
                    want = frame_results_due.pop_front();
                    check_field("status", want.status, status);
                    check_field("command", want.command, command);
                    check_field("payload_byte", want.payload_byte, payload_byte);
                    check_field("byte_index", want.byte_index, byte_index);
                    check_field("last", want.last, last);
                    check_field("good_count", want.good_count, good_count);
                    check_field("bad_count", want.bad_count, bad_count);
                end
            end

            if (in_valid && in_ready)
                predict_byte(rx_byte);

            mismatches       <= fault_count;
            pending          <= frame_results_due.size();
            results_seen     <= result_count;
            good_frames_seen <= int'(good_total);
            crc_errors_seen  <= int'(bad_total);
        end
    end

endmodule

`default_nettype wire

// File: verif/tb_sync_length_crc8_frame_receiver.sv
// frame receiver testbench top: clock, reset, byte and config stimulus, verdict
`default_nettype none

module tb_sync_length_crc8_frame_receiver;
    timeunit 1ns;
    timeprecision 1ps;

    import slcfr_pkg::*;

    localparam int         HALF_PERIOD  = 10;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         HOLD_CYCLES  = 400;
    localparam logic [1:0] REG_UNUSED   = 2'd3;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  rx_byte   = 8'h00;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = REG_START_ONE;
    logic [7:0]  cfg_data  = 8'h00;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic        cfg_ready;
    logic        out_valid;
    logic [1:0]  status;
    logic [7:0]  command;
    logic [7:0]  payload_byte;
    logic [5:0]  byte_index;
    logic        last;
    logic [31:0] good_count;
    logic [31:0] bad_count;

    int mismatches;
    int pending;
    int results_seen;
    int good_frames_seen;
    int crc_errors_seen;

    // stimulus-side copy of the settings, used to shape frames
    logic [7:0] sof_one   = START_ONE_RESET;
    logic [7:0] sof_two   = START_TWO_RESET;
    int         len_limit = MAX_FRAME_DEFAULT;
    logic [7:0] frame_body [MAX_FRAME_DEFAULT];

    bit calm        = 1'b0;
    int stall_req   = 0;
    int bytes_sent  = 0;
    int reg_writes  = 0;
    int cycles      = 0;

    sync_length_crc8_frame_receiver u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .command      (command),
        .payload_byte (payload_byte),
        .byte_index   (byte_index),
        .last         (last),
        .good_count   (good_count),
        .bad_count    (bad_count)
    );

    slcfr_frame_checker u_frame_check
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .rx_byte          (rx_byte),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .command          (command),
        .payload_byte     (payload_byte),
        .byte_index       (byte_index),
        .last             (last),
        .good_count       (good_count),
        .bad_count        (bad_count),
        .mismatches       (mismatches),
        .pending          (pending),
        .results_seen     (results_seen),
        .good_frames_seen (good_frames_seen),
        .crc_errors_seen  (crc_errors_seen)
    );

    always
    begin
        #(HALF_PERIOD) clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: random back-pressure, plus a long hold-off on request
    initial
    begin : result_sink
        int hold;
        int stalls_done;
        stalls_done = 0;
        forever
        begin
            @(posedge clk);
            if (stall_req != stalls_done)
            begin
                stalls_done = stall_req;
                out_ready <= 1'b0;
                for (hold = 0; hold < HOLD_CYCLES; hold++)
                    @(posedge clk);
            end
            out_ready <= calm || ($urandom_range(99) >= 35);
        end
    end

    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        repeat (8)
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        return c;
    endfunction

    // one byte transfer, with an occasional gap before it
    task automatic send_byte(input logic [7:0] value);
        if (!calm && $urandom_range(99) < 35)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 2))
                @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // start bytes, length, then frame_body[0..plen] and the crc
    task automatic send_frame(input int plen, input bit crc_good, input int extra_starts);
        logic [7:0] crc;
        int         i;
        crc = 8'h00;
        repeat (extra_starts + 1)
            send_byte(sof_one);
        send_byte(sof_two);
        send_byte(8'(plen + 2));
        for (i = 0; i <= plen; i++)
        begin
            crc = crc8_next(crc, frame_body[i]);
            send_byte(frame_body[i]);
        end
        send_byte(crc_good ? crc : crc ^ 8'($urandom_range(1, 255)));
    endtask

    task automatic random_body(input int plen);
        int i;
        for (i = 0; i <= plen; i++)
            frame_body[i] = 8'($urandom_range(255));
    endtask

    // mostly well-formed frames, with bad lengths, broken headers and noise mixed in
    task automatic random_traffic(input int budget);
        int spent;
        int pick;
        int plen;
        int cap;
        int starts;
        spent = 0;
        while (spent < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                cap = (len_limit - 2 < 8) ? len_limit - 2 : 8;
                if (len_limit < 2)
                    plen = $urandom_range(3);
                else if ($urandom_range(99) < 4)
                    plen = len_limit - 2;
                else
                    plen = $urandom_range(cap);
                starts = (sof_one != sof_two && $urandom_range(99) < 20) ?
                         $urandom_range(1, 2) : 0;
                random_body(plen);
                send_frame(plen, $urandom_range(99) < 85, starts);
                spent += plen + 4 + starts;
            end
            else if (pick < 85)
            begin
                send_byte(sof_one);
                send_byte(sof_two);
                case ($urandom_range(2))
                    0:       send_byte(8'd0);
                    1:       send_byte(8'd1);
                    default: send_byte(8'($urandom_range(len_limit + 1, 255)));
                endcase
                spent += 3;
            end
            else if (pick < 92)
            begin
                send_byte(sof_one);
                send_byte(8'($urandom_range(255)));
                spent += 2;
            end
            else
            begin
                send_byte(8'($urandom_range(255)));
                spent += 1;
            end
        end
    endtask

    // leaves cfg_valid high so that back-to-back writes need no re-raise
    task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        reg_writes++;
        case (index)
            REG_START_ONE:  sof_one = value;
            REG_START_TWO:  sof_two = value;
            REG_MAX_LENGTH: len_limit = (value[6:0] > MAX_FRAME_DEFAULT) ?
                                        MAX_FRAME_DEFAULT : value[6:0];
            default:        ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] one, input logic [7:0] two,
                              input logic [7:0] limit_raw, input bit poke_unused);
        if (poke_unused)
            write_reg(REG_UNUSED, 8'($urandom_range(255)));
        write_reg(REG_START_ONE, one);
        write_reg(REG_START_TWO, two);
        write_reg(REG_MAX_LENGTH, limit_raw);
        cfg_valid <= 1'b0;
    endtask

    // stop offering bytes and wait for every predicted result to come out
    task automatic settle();
        in_valid <= 1'b0;
        repeat (2)
            @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // repeated first start byte, then a frame with no payload
        frame_body[0] = 8'h00;
        send_frame(0, 1'b1, 1);
        // payload at both byte extremes
        frame_body[0] = 8'hFF;
        frame_body[1] = 8'h00;
        frame_body[2] = 8'hFF;
        send_frame(2, 1'b1, 0);
        // corrupted crc
        frame_body[0] = 8'h5A;
        frame_body[1] = 8'h33;
        send_frame(1, 1'b0, 0);
        // lengths below two and above the limit abandon the frame
        send_byte(sof_one);
        send_byte(sof_two);
        send_byte(8'd1);
        send_byte(sof_one);
        send_byte(sof_two);
        send_byte(8'd65);
        // first start byte followed by a stray byte restarts the hunt
        send_byte(sof_one);
        send_byte(8'h12);

        // results held back for a long stretch while frames keep arriving
        stall_req <= stall_req + 1;
        random_body(3);
        send_frame(3, 1'b1, 0);
        random_body(2);
        send_frame(2, 1'b1, 0);
        random_traffic(6);
        settle();

        set_config(8'h00, 8'hFF, 8'd2, 1'b1);
        random_traffic(5);
        settle();

        // limit above the store saturates; the largest frame with no idling on either side
        set_config(8'hFF, 8'h00, 8'h7F, 1'b0);
        calm <= 1'b1;
        random_body(MAX_FRAME_DEFAULT - 2);
        send_frame(MAX_FRAME_DEFAULT - 2, 1'b1, 0);
        random_traffic(4);
        settle();
        calm <= 1'b0;

        // no length accepted at all
        set_config(8'($urandom_range(255)), 8'($urandom_range(255)), 8'd0, 1'b0);
        random_traffic(3);
        settle();
        set_config(8'($urandom_range(255)), 8'($urandom_range(255)), 8'h81, 1'b0);
        random_traffic(3);
        settle();

        set_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'h80 | 8'($urandom_range(2, MAX_FRAME_DEFAULT)), 1'b0);
        random_traffic(4);
        settle();

        set_config(8'($urandom_range(255)), 8'($urandom_range(255)), 8'hC5, 1'b1);
        random_traffic(4);
        settle();

        $display("run covered %0d input bytes and %0d register writes", bytes_sent, reg_writes);
        $display("%0d results out: %0d good frames, %0d crc errors",
                 results_seen, good_frames_seen, crc_errors_seen);
        if (mismatches == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
